/* rtl/lbp_pkg.sv */
// Shared types, constants and helpers for the 3x3 LBP code stream block.
`timescale 1ns / 1ps

package lbp_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;

  localparam int PIX_W  = 8;
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int SIZE_W = 11;
  localparam int ADDR_W = 3;
  localparam int DATA_W = 32;

  localparam logic [SIZE_W-1:0] MIN_SIZE      = SIZE_W'(3);
  localparam logic [SIZE_W-1:0] MAX_WIDTH_SZ  = SIZE_W'(MAX_WIDTH);
  localparam logic [SIZE_W-1:0] MAX_HEIGHT_SZ = SIZE_W'(MAX_HEIGHT);
  localparam logic [SIZE_W-1:0] RESET_WIDTH   = SIZE_W'(640);
  localparam logic [SIZE_W-1:0] RESET_HEIGHT  = SIZE_W'(480);

  // register select bit of paddr (byte address 4*i)
  localparam logic REG_FRAME_WIDTH  = 1'b0;
  localparam logic REG_FRAME_HEIGHT = 1'b1;

  typedef logic [PIX_W-1:0] pix_t;

  // one line store entry: pixel two rows up and pixel one row up
  typedef struct packed {
    pix_t upper;
    pix_t middle;
  } line_entry_t;

  // control carried with the item in the window stage
  typedef struct packed {
    logic valid;
    logic emit;
    logic last;
  } stage_ctl_t;

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] hi);
    logic [SIZE_W-1:0] res;
    res = v;
    if (v < MIN_SIZE) res = MIN_SIZE;
    else if (v > hi) res = hi;
    return res;
  endfunction

endpackage

/* rtl/lbp_cfg_regs.sv */
// APB frame size registers with clamped effective sizes.
`timescale 1ns / 1ps

module lbp_cfg_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lbp_pkg::ADDR_W-1:0]  paddr,
  input  logic [lbp_pkg::DATA_W-1:0]  pwdata,
  output logic [lbp_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output logic [lbp_pkg::SIZE_W-1:0]  width_eff,
  output logic [lbp_pkg::SIZE_W-1:0]  height_eff
);
  import lbp_pkg::*;

  logic [SIZE_W-1:0] frame_width;
  logic [SIZE_W-1:0] frame_height;
  logic              wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= RESET_WIDTH;
      frame_height <= RESET_HEIGHT;
    end else if (wr_en) begin
      case (paddr[2])
        REG_FRAME_WIDTH:  frame_width  <= pwdata[SIZE_W-1:0];
        REG_FRAME_HEIGHT: frame_height <= pwdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (paddr[2])
      REG_FRAME_WIDTH:  prdata = DATA_W'(frame_width);
      REG_FRAME_HEIGHT: prdata = DATA_W'(frame_height);
      default:          prdata = '0;
    endcase
  end

  assign width_eff  = clamp_size(frame_width, MAX_WIDTH_SZ);
  assign height_eff = clamp_size(frame_height, MAX_HEIGHT_SZ);

endmodule

/* rtl/lbp_line_store.sv */
// Two-row line store: one write port, one registered read port.
`timescale 1ns / 1ps

module lbp_line_store (
  input  logic                        clk,
  input  logic                        wr_en,
  input  logic [lbp_pkg::COL_W-1:0]   wr_addr,
  input  lbp_pkg::line_entry_t        wr_data,
  input  logic                        rd_en,
  input  logic [lbp_pkg::COL_W-1:0]   rd_addr,
  output lbp_pkg::line_entry_t        rd_data
);
  import lbp_pkg::*;

  line_entry_t mem [MAX_WIDTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/lbp_code_unit.sv */
// 3x3 window registers and the neighbour-greater-than-centre compare.
`timescale 1ns / 1ps

module lbp_code_unit (
  input  logic          clk,
  input  logic          rst,
  input  logic          advance,
  input  lbp_pkg::pix_t top,
  input  lbp_pkg::pix_t mid,
  input  lbp_pkg::pix_t bot,
  output lbp_pkg::pix_t code
);
  import lbp_pkg::*;

  // win[0..2]: left column (top, mid, bot); win[3..5]: middle column
  pix_t win [6];
  pix_t ctr;

  assign ctr = win[4];

  // bit 7 top-left, clockwise to bit 0 left
  always_comb begin
    code[7] = win[0] > ctr;
    code[6] = win[3] > ctr;
    code[5] = top    > ctr;
    code[4] = mid    > ctr;
    code[3] = bot    > ctr;
    code[2] = win[5] > ctr;
    code[1] = win[2] > ctr;
    code[0] = win[1] > ctr;
  end

  // window shifts one column per item
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) win[i] <= '0;
    end else if (advance) begin
      win[0] <= win[3];
      win[1] <= win[4];
      win[2] <= win[5];
      win[3] <= top;
      win[4] <= mid;
      win[5] <= bot;
    end
  end

endmodule

/* rtl/lbp_3x3_code_stream.sv */
// Top level: 3x3 local binary pattern codes from a raster pixel stream.
`timescale 1ns / 1ps
//
// Pixels enter on the s_axis channel, one 8-bit pixel per transfer in raster
// order. For every interior pixel an 8-bit LBP code leaves on m_axis; tlast
// marks the code completed by the frame's last pixel. Border rows and columns
// give no code. Frame width and height are APB registers at byte addresses 0
// and 4, clamped to 3..1024; they must be written only while the stream is
// idle, and the block does not enforce this. Throughput: one pixel per cycle,
// sustained while the receiver accepts codes. The rate is set by the line
// store, a 1024 x 16 memory read once per pixel at its column and written
// back at that column as the pixel leaves the window stage; successive
// pixels always touch different columns, so no interlock is needed. The pixel
// completing a window passes the window stage (memory read), then the output
// register, before its code is valid on m_axis. When the receiver stalls the
// output register holds its code and the window stage waits; s_axis_tready
// drops once the window stage is also full. Reset clears position counters,
// window and valid flags, and restores the size registers to 640 x 480. The
// line store contents are not cleared.
module lbp_3x3_code_stream (
  input  logic                        clk,
  input  logic                        rst,
  // input pixels
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [7:0]                  s_axis_tdata,   // [7:0] pixel
  // output codes
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [7:0]                  m_axis_tdata,   // [7:0] lbp_code
  output logic                        m_axis_tlast,   // frame_last
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lbp_pkg::ADDR_W-1:0]  paddr,
  input  logic [lbp_pkg::DATA_W-1:0]  pwdata,
  output logic [lbp_pkg::DATA_W-1:0]  prdata,
  output logic                        pready
);
  import lbp_pkg::*;

  logic [SIZE_W-1:0] width_eff;
  logic [SIZE_W-1:0] height_eff;

  logic [COL_W-1:0]  column_count;
  logic [ROW_W-1:0]  row_count;
  logic              col_wrap;
  logic              row_wrap;
  logic              s_accept;

  stage_ctl_t        s1_ctl;
  pix_t              s1_pixel;
  logic [COL_W-1:0]  s1_col;
  logic              s1_go;

  line_entry_t       rd_entry;
  line_entry_t       wr_entry;
  pix_t              code;

  lbp_cfg_regs u_cfg (
    .clk        (clk),
    .rst        (rst),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .width_eff  (width_eff),
    .height_eff (height_eff)
  );

  // window stage moves on unless its code has nowhere to go
  assign s1_go         = s1_ctl.valid && (!s1_ctl.emit || !m_axis_tvalid || m_axis_tready);
  assign s_axis_tready = !s1_ctl.valid || s1_go;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  // end of row / end of frame at the current position
  assign col_wrap = ({1'b0, column_count} + SIZE_W'(1)) >= width_eff;
  assign row_wrap = ({1'b0, row_count} + SIZE_W'(1)) >= height_eff;

  // raster position counters
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (s_accept) begin
      if (col_wrap) begin
        column_count <= '0;
        row_count    <= row_wrap ? '0 : row_count + ROW_W'(1);
      end else begin
        column_count <= column_count + COL_W'(1);
      end
    end
  end

  // window stage register: item waits here for the line store read data
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_ctl <= '0;
    end else if (s_accept) begin
      s1_ctl.valid <= 1'b1;
      s1_ctl.emit  <= (row_count >= ROW_W'(2)) && (column_count >= COL_W'(2));
      s1_ctl.last  <= row_wrap && col_wrap;
    end else if (s1_go) begin
      s1_ctl.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      s1_pixel <= s_axis_tdata;
      s1_col   <= column_count;
    end
  end

  // rows shift down by one in the store entry
  assign wr_entry.upper  = rd_entry.middle;
  assign wr_entry.middle = s1_pixel;

  lbp_line_store u_store (
    .clk     (clk),
    .wr_en   (s1_go),
    .wr_addr (s1_col),
    .wr_data (wr_entry),
    .rd_en   (s_accept),
    .rd_addr (column_count),
    .rd_data (rd_entry)
  );

  lbp_code_unit u_code (
    .clk     (clk),
    .rst     (rst),
    .advance (s1_go),
    .top     (rd_entry.upper),
    .mid     (rd_entry.middle),
    .bot     (s1_pixel),
    .code    (code)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (s1_go && s1_ctl.emit) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1_ctl.emit) begin
      m_axis_tdata <= code;
      m_axis_tlast <= s1_ctl.last;
    end
  end

endmodule
